FILE: rtl/dbsv_pkg.sv
// ----------------------------------------------------------------------------
// dbsv_pkg
// shared types, codes and constants of the dual bank save validator
// ----------------------------------------------------------------------------
`default_nettype none

package dbsv_pkg;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BLK_W    = 5;
  localparam int unsigned HSUM_W   = 16;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BIU_W    = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // stream widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 40;

  // defaults
  localparam int unsigned MAX_BLOCKS_DEF = 32;
  localparam logic [BIU_W-1:0] BLOCKS_IN_USE_RST = 6'd14;

  // opcodes
  localparam logic [OP_W-1:0] OP_DATA       = 2'd0;
  localparam logic [OP_W-1:0] OP_SECTOR_END = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH     = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR      = 2'd3;

  // status / bank class codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DAMAGED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DESTROYED = 2'd3;

  // result kinds
  localparam logic KIND_SECTOR  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_MAGIC    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

  // counter values that wrap against each other
  localparam logic [CNT_W-1:0] CNT_ZERO = 32'h0000_0000;
  localparam logic [CNT_W-1:0] CNT_MAX  = 32'hffff_ffff;

  typedef struct packed {
    logic [CNT_W-1:0]  header_count;
    logic [HSUM_W-1:0] header_sum;
    logic [BLK_W-1:0]  header_block;
    logic [WORD_W-1:0] header_id;
    logic              bank;
    logic [WORD_W-1:0] data_word;
    logic [OP_W-1:0]   opcode;
  } item_t;

  typedef struct packed {
    logic                active_bank;
    logic [CNT_W-1:0]    chosen_counter;
    logic [STATUS_W-1:0] status;
    logic                sector_valid;
    logic                result_kind;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/dual_bank_save_validator.sv
// ----------------------------------------------------------------------------
// dual_bank_save_validator
// checks two mirrored flash save banks and selects the bank to use
// ----------------------------------------------------------------------------
// Items enter through an input register and are worked in a single pass of
// logic into an output register, one item per cycle with no bubbles unless a
// result-making held item meets a stalled output. The 32-bit word add and
// the header compares work on the item in the input register. A data word
// adds into the running sum; a sector end folds the sum to 16 bits, checks
// the magic id and stored sum, updates the bank's present flag, block mask
// and counter, and returns one sector result; a finish item returns the
// verdict with the chosen counter; a clear item wipes the kept state. Data
// words and clears give no result. The input side keeps taking items while
// a result waits at the output as long as the held item makes no result or
// the output slot frees up. The user writes configuration through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_bank_save_validator #(
  parameter int unsigned MAX_BLOCKS = dbsv_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [dbsv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dbsv_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // data_word[31:0], bank[32], header_id[64:33], header_block[69:65],
  // header_sum[85:70], header_count[117:86], zero pad[119:118]
  input  wire logic [dbsv_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode[1:0]
  input  wire logic [dbsv_pkg::OP_W-1:0]           in_tuser,
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // sector_valid[0], status[2:1], chosen_counter[34:3], active_bank[35],
  // zero pad[39:36]
  output logic [dbsv_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // result_kind[0]
  output logic                                     out_tuser
);
  import dbsv_pkg::*;

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned RES_W  = $bits(result_t);

  // configuration registers
  logic [WORD_W-1:0] save_magic_r;
  logic [BIU_W-1:0]  blocks_in_use_r;

  // input register
  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;

  // output register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic in_xfer;
  logic s1_has_result;
  logic out_free;
  logic s1_adv;
  item_t in_item;
  result_t res;

  logic                        sector_valid;
  logic [1:0]                  present;
  logic [1:0][MAX_BLOCKS-1:0]  block_mask;
  logic [1:0][CNT_W-1:0]       counter;
  logic [STATUS_W-1:0]         v_status;
  logic [CNT_W-1:0]            v_counter;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      save_magic_r    <= '0;
      blocks_in_use_r <= BLOCKS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAVE_MAGIC:    save_magic_r    <= cfg_wdata[WORD_W-1:0];
        CFG_BLOCKS_IN_USE: blocks_in_use_r <= cfg_wdata[BIU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // unpack the stream into an item, opcode from tuser
  assign in_item = item_t'({in_tdata[ITEM_W-OP_W-1:0], in_tuser});

  // the held item moves on when it makes no result or the output slot is free
  assign s1_has_result = (s1_item_r.opcode == OP_SECTOR_END) ||
                         (s1_item_r.opcode == OP_FINISH);
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_has_result || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
  end

  // kept state and sector check
  dbsv_bank_state #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (s1_adv),
    .item         (s1_item_r),
    .save_magic   (save_magic_r),
    .sector_valid (sector_valid),
    .present      (present),
    .block_mask   (block_mask),
    .counter      (counter)
  );

  // finish verdict
  dbsv_verdict #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_verdict (
    .blocks_in_use  (blocks_in_use_r),
    .present        (present),
    .block_mask     (block_mask),
    .counter        (counter),
    .status         (v_status),
    .chosen_counter (v_counter)
  );

  // sector results carry zeros in the verdict fields and vice versa
  always_comb begin
    res = '0;
    if (s1_item_r.opcode == OP_FINISH) begin
      res.result_kind    = KIND_VERDICT;
      res.status         = v_status;
      res.chosen_counter = v_counter;
      res.active_bank    = v_counter[0];
    end else begin
      res.result_kind  = KIND_SECTOR;
      res.sector_valid = sector_valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_has_result) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.result_kind;
  assign out_tdata  = OUT_TDATA_W'(out_res_r[RES_W-1:1]);

  // a sector end that moves on shows up as a sector result next cycle
  a_sector_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item_r.opcode == OP_SECTOR_END) |=>
      (out_tvalid && out_tuser == KIND_SECTOR))
    else $error("sector end did not produce a sector result");

  // a finish item that moves on shows up as a verdict next cycle
  a_verdict_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item_r.opcode == OP_FINISH) |=>
      (out_tvalid && out_tuser == KIND_VERDICT))
    else $error("finish did not produce a verdict");

  // a clear leaves both banks empty
  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item_r.opcode == OP_CLEAR) |=> (present == 2'b00))
    else $error("clear left a bank marked present");

  // without a good bank the counter reads zero
  a_no_bank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_VERDICT &&
     (out_res_r.status == ST_EMPTY || out_res_r.status == ST_DESTROYED)) |->
      (out_res_r.chosen_counter == CNT_ZERO))
    else $error("counter reported without a usable bank");

endmodule

`default_nettype wire

FILE: rtl/dbsv_bank_state.sv
// ----------------------------------------------------------------------------
// dbsv_bank_state
// word accumulator, sector header check and per-bank kept state
// ----------------------------------------------------------------------------
`default_nettype none

module dbsv_bank_state #(
  parameter int unsigned MAX_BLOCKS = dbsv_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          upd,
  input  wire dbsv_pkg::item_t               item,
  input  wire logic [dbsv_pkg::WORD_W-1:0]   save_magic,
  output logic                               sector_valid,
  output logic [1:0]                         present,
  output logic [1:0][MAX_BLOCKS-1:0]         block_mask,
  output logic [1:0][dbsv_pkg::CNT_W-1:0]    counter
);
  import dbsv_pkg::*;

  logic [WORD_W-1:0]            word_sum_r, word_sum_nxt;
  logic [1:0]                   present_r, present_nxt;
  logic [1:0][MAX_BLOCKS-1:0]   mask_r, mask_nxt;
  logic [1:0][CNT_W-1:0]        cnt_r, cnt_nxt;

  logic [HSUM_W-1:0]            fold;
  logic                         id_match;
  logic [MAX_BLOCKS-1:0]        blk_bit;

  // fold the running sum to 16 bits
  assign fold     = word_sum_r[WORD_W-1:HSUM_W] + word_sum_r[HSUM_W-1:0];
  assign id_match = (item.header_id == save_magic);
  assign sector_valid = id_match && (item.header_sum == fold);

  // block numbers at or above MAX_BLOCKS match no bit
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_blk
    assign blk_bit[i] = (item.header_block == BLK_W'(i));
  end

  always_comb begin
    word_sum_nxt = word_sum_r;
    present_nxt  = present_r;
    mask_nxt     = mask_r;
    cnt_nxt      = cnt_r;
    if (upd) begin
      case (item.opcode)
        OP_DATA: begin
          word_sum_nxt = word_sum_r + item.data_word;
        end
        OP_SECTOR_END: begin
          word_sum_nxt = '0;
          if (id_match) begin
            present_nxt[item.bank] = 1'b1;
          end
          if (sector_valid) begin
            cnt_nxt[item.bank]  = item.header_count;
            mask_nxt[item.bank] = mask_r[item.bank] | blk_bit;
          end
        end
        OP_CLEAR: begin
          word_sum_nxt = '0;
          present_nxt  = '0;
          mask_nxt     = '0;
          cnt_nxt      = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_sum_r <= '0;
      present_r  <= '0;
      mask_r     <= '0;
      cnt_r      <= '0;
    end else begin
      word_sum_r <= word_sum_nxt;
      present_r  <= present_nxt;
      mask_r     <= mask_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  assign present    = present_r;
  assign block_mask = mask_r;
  assign counter    = cnt_r;

endmodule

`default_nettype wire

FILE: rtl/dbsv_verdict.sv
// ----------------------------------------------------------------------------
// dbsv_verdict
// classifies both banks and picks the bank and counter to use
// ----------------------------------------------------------------------------
`default_nettype none

module dbsv_verdict #(
  parameter int unsigned MAX_BLOCKS = dbsv_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic [dbsv_pkg::BIU_W-1:0]        blocks_in_use,
  input  wire logic [1:0]                        present,
  input  wire logic [1:0][MAX_BLOCKS-1:0]        block_mask,
  input  wire logic [1:0][dbsv_pkg::CNT_W-1:0]   counter,
  output logic [dbsv_pkg::STATUS_W-1:0]          status,
  output logic [dbsv_pkg::CNT_W-1:0]             chosen_counter
);
  import dbsv_pkg::*;

  logic [MAX_BLOCKS-1:0] full_mask;
  logic [1:0][STATUS_W-1:0] cls;
  logic wrap_pair;

  // low blocks_in_use bits set, clamped to MAX_BLOCKS
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_full
    assign full_mask[i] = (BIU_W'(i) < blocks_in_use);
  end

  for (genvar b = 0; b < 2; b++) begin : g_cls
    assign cls[b] = !present[b] ? ST_EMPTY :
                    (block_mask[b] == full_mask) ? ST_OK : ST_DAMAGED;
  end

  assign wrap_pair = (counter[0] == CNT_MAX && counter[1] == CNT_ZERO) ||
                     (counter[0] == CNT_ZERO && counter[1] == CNT_MAX);

  always_comb begin
    chosen_counter = CNT_ZERO;
    status         = ST_DESTROYED;
    if (cls[0] == ST_OK && cls[1] == ST_OK) begin
      status = ST_OK;
      if (wrap_pair) begin
        chosen_counter = CNT_ZERO;
      end else begin
        chosen_counter = (counter[0] < counter[1]) ? counter[1] : counter[0];
      end
    end else if (cls[0] == ST_OK) begin
      chosen_counter = counter[0];
      status = (cls[1] == ST_DAMAGED) ? ST_DAMAGED : ST_OK;
    end else if (cls[1] == ST_OK) begin
      chosen_counter = counter[1];
      status = (cls[0] == ST_DAMAGED) ? ST_DAMAGED : ST_OK;
    end else if (cls[0] == ST_EMPTY && cls[1] == ST_EMPTY) begin
      status = ST_EMPTY;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_dual_bank_save_validator.sv
// ----------------------------------------------------------------------------
// tb_dual_bank_save_validator
// self-checking testbench for the dual bank save validator
// ----------------------------------------------------------------------------
// A short table of directed items runs first: reset state, sum wrap, bad id,
// bad checksum, counter wrap between two complete banks, a damaged partner
// and a zero block count. Random phases follow under several register
// settings and idle patterns. Each phase plays whole save images (clear, both
// banks sector by sector, verdict) with random content, plus some noise. A
// local model of the block predicts each result from the accepted items, and
// every result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dual_bank_save_validator;
  timeunit 1ns;
  timeprecision 1ps;

  import dbsv_pkg::*;

  localparam int unsigned MAX_BLK     = MAX_BLOCKS_DEF;
  localparam int          STALL_LIMIT = 4000;
  localparam int          PHASE_ITEMS = 200;
  localparam int          NUM_PHASES  = 8;

  // one row of the directed table: a register write or an item, with an
  // optional hand-written expected result
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    item_t                 it;
    logic                  typed;
    result_t               want;
  } row_t;

  // what the sender attached to the item now on offer
  typedef struct packed {
    logic    typed;
    result_t want;
  } tag_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tuser;

  dual_bank_save_validator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // local model of the validator
  // --------------------------------------------------------------------------
  logic [31:0]      magic_reg  = CNT_ZERO;
  logic [BIU_W-1:0] blocks_reg = BLOCKS_IN_USE_RST;
  logic [31:0]      acc_sum    = '0;
  logic [1:0]       present    = '0;
  logic [31:0]      blk_mask [2] = '{32'd0, 32'd0};
  logic [31:0]      bank_cnt [2] = '{32'd0, 32'd0};

  function automatic logic [15:0] fold16(input logic [31:0] s);
    return s[31:16] + s[15:0];
  endfunction

  // empty, ok or damaged for one bank under the current block count
  function automatic logic [STATUS_W-1:0] bank_class(input int b);
    int unsigned n;
    logic [31:0] need;
    if (!present[b]) return ST_EMPTY;
    n = (blocks_reg > MAX_BLK) ? MAX_BLK : blocks_reg;
    need = (n >= 32) ? 32'hffff_ffff : ((32'd1 << n) - 32'd1);
    return (blk_mask[b] == need) ? ST_OK : ST_DAMAGED;
  endfunction

  // advances the model by one item; returns 1 when the item yields a result
  function automatic bit score_item(input item_t it, output result_t r);
    logic [15:0] f;
    logic [STATUS_W-1:0] k0, k1;
    int b;
    r = '0;
    b = it.bank;
    case (it.opcode)
      OP_DATA: begin
        acc_sum = acc_sum + it.data_word;
        return 1'b0;
      end
      OP_CLEAR: begin
        acc_sum = '0;
        present = '0;
        blk_mask[0] = '0;
        blk_mask[1] = '0;
        bank_cnt[0] = '0;
        bank_cnt[1] = '0;
        return 1'b0;
      end
      OP_SECTOR_END: begin
        f = fold16(acc_sum);
        acc_sum = '0;
        r.result_kind = KIND_SECTOR;
        // a matching id marks the bank present even when the sum is bad
        if (it.header_id == magic_reg) begin
          present[b] = 1'b1;
          if (it.header_sum == f) begin
            r.sector_valid = 1'b1;
            bank_cnt[b] = it.header_count;
            if (it.header_block < MAX_BLK) blk_mask[b][it.header_block] = 1'b1;
          end
        end
        return 1'b1;
      end
      default: begin
        k0 = bank_class(0);
        k1 = bank_class(1);
        r.result_kind = KIND_VERDICT;
        if (k0 == ST_OK && k1 == ST_OK) begin
          // 0 beats all ones: the counter has wrapped
          if ((bank_cnt[0] == CNT_MAX && bank_cnt[1] == CNT_ZERO) ||
              (bank_cnt[0] == CNT_ZERO && bank_cnt[1] == CNT_MAX))
            r.chosen_counter = CNT_ZERO;
          else
            r.chosen_counter = (bank_cnt[0] < bank_cnt[1]) ? bank_cnt[1] : bank_cnt[0];
          r.status = ST_OK;
        end else if (k0 == ST_OK) begin
          r.chosen_counter = bank_cnt[0];
          r.status = (k1 == ST_DAMAGED) ? ST_DAMAGED : ST_OK;
        end else if (k1 == ST_OK) begin
          r.chosen_counter = bank_cnt[1];
          r.status = (k0 == ST_DAMAGED) ? ST_DAMAGED : ST_OK;
        end else if (k0 == ST_EMPTY && k1 == ST_EMPTY) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_DESTROYED;
        end
        r.active_bank = r.chosen_counter[0];
        return 1'b1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // scoreboard: results first, then the input transfer of the same edge
  // --------------------------------------------------------------------------
  result_t results_due [$];
  tag_t    offer_tags [$];
  item_t   cur_item = '0;
  int      fail_cnt = 0;
  int      items_sent = 0;

  always @(posedge clk) begin
    result_t got, exp_r, guess;
    tag_t tag;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.result_kind    = out_tuser;
        got.sector_valid   = out_tdata[0];
        got.status         = out_tdata[2:1];
        got.chosen_counter = out_tdata[34:3];
        got.active_bank    = out_tdata[35];
        if (results_due.size() == 0) begin
          $error("result transfer with nothing expected (kind %0d)", got.result_kind);
          fail_cnt++;
        end else begin
          exp_r = results_due.pop_front();
          if (got.result_kind !== exp_r.result_kind) begin
            $error("result_kind: expected %0d, got %0d", exp_r.result_kind, got.result_kind);
            fail_cnt++;
          end
          if (got.sector_valid !== exp_r.sector_valid) begin
            $error("sector_valid: expected %0d, got %0d",
                   exp_r.sector_valid, got.sector_valid);
            fail_cnt++;
          end
          if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            fail_cnt++;
          end
          if (got.chosen_counter !== exp_r.chosen_counter) begin
            $error("chosen_counter: expected %08h, got %08h",
                   exp_r.chosen_counter, got.chosen_counter);
            fail_cnt++;
          end
          if (got.active_bank !== exp_r.active_bank) begin
            $error("active_bank: expected %0d, got %0d", exp_r.active_bank, got.active_bank);
            fail_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        tag = offer_tags.pop_front();
        if (score_item(cur_item, guess))
          results_due.push_back(tag.typed ? tag.want : guess);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: cycles without any transfer
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** dual_bank_save_validator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  int rx_stall_pct = 0;
  int tx_idle_pct  = 0;
  int hold_left    = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a falling edge
  // --------------------------------------------------------------------------
  logic [31:0] gen_sum = '0;  // word sum as the block sees it, for building good headers

  function automatic item_t mk_item(input logic [OP_W-1:0] op, input logic [31:0] word,
                                    input logic bank, input logic [31:0] id,
                                    input logic [BLK_W-1:0] blk, input logic [15:0] hsum,
                                    input logic [31:0] cnt);
    item_t it;
    it.opcode       = op;
    it.data_word    = word;
    it.bank         = bank;
    it.header_id    = id;
    it.header_block = blk;
    it.header_sum   = hsum;
    it.header_count = cnt;
    return it;
  endfunction

  task automatic send_item(input item_t it, input logic typed, input result_t want);
    tag_t tag;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    tag.typed = typed;
    tag.want  = want;
    offer_tags.push_back(tag);
    cur_item  = it;
    in_tuser  = it.opcode;
    in_tdata  = {2'b00, it.header_count, it.header_sum, it.header_block,
                 it.header_id, it.bank, it.data_word};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (it.opcode == OP_DATA) gen_sum = gen_sum + it.data_word;
    else if (it.opcode != OP_FINISH) gen_sum = '0;
  endtask

  // drop valid, let every expected result come out, then allow for the
  // input register that may still hold a word or a clear
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == CFG_SAVE_MAGIC) magic_reg = val;
    else blocks_reg = val[BIU_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one save image: optional clear, both banks sector by sector, verdict
  task automatic play_save();
    int unsigned nsec, k, w, nw, mode;
    int b;
    logic [31:0] cnt, id, word;
    logic [15:0] hs;
    logic [4:0]  blk;
    if ($urandom_range(0, 3) != 0)
      send_item(mk_item(OP_CLEAR, $urandom, 1'b0, $urandom, 5'd0, 16'd0, $urandom), 1'b0, '0);
    for (b = 0; b < 2; b++) begin
      // mode 0 sends no sector to the bank, mode 1 drops sectors here and there
      mode = $urandom_range(0, 9);
      case ($urandom_range(0, 5))
        0:       cnt = CNT_ZERO;
        1:       cnt = CNT_MAX;
        2:       cnt = $urandom_range(0, 3);
        default: cnt = $urandom;
      endcase
      nsec = (blocks_reg > MAX_BLK) ? MAX_BLK : blocks_reg;
      if (nsec == 0) nsec = $urandom_range(0, 2);
      if (mode != 0) begin
        for (k = 0; k < nsec; k++) begin
          if (mode == 1 && $urandom_range(0, 3) == 0) continue;
          nw = $urandom_range(0, 3);
          for (w = 0; w < nw; w++) begin
            word = ($urandom_range(0, 7) == 0) ? CNT_MAX : $urandom;
            send_item(mk_item(OP_DATA, word, $urandom_range(0, 1), $urandom,
                              $urandom_range(0, 31), $urandom_range(0, 65535), $urandom),
                      1'b0, '0);
          end
          id  = ($urandom_range(0, 19) == 0) ? $urandom : magic_reg;
          hs  = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535)) : fold16(gen_sum);
          blk = (blocks_reg == 0 || $urandom_range(0, 19) == 0) ?
                5'($urandom_range(0, 31)) : 5'(k);
          send_item(mk_item(OP_SECTOR_END, $urandom, b[0], id, blk, hs,
                            ($urandom_range(0, 19) == 0) ? $urandom : cnt), 1'b0, '0);
        end
      end
    end
    send_item(mk_item(OP_FINISH, $urandom, $urandom_range(0, 1), $urandom,
                      $urandom_range(0, 31), $urandom_range(0, 65535), $urandom), 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  function automatic row_t item_row(input logic [OP_W-1:0] op, input logic [31:0] word,
                                    input logic bank, input logic [31:0] id,
                                    input logic [BLK_W-1:0] blk, input logic [15:0] hsum,
                                    input logic [31:0] cnt, input logic typed,
                                    input result_t want);
    row_t r;
    r = '0;
    r.it    = mk_item(op, word, bank, id, blk, hsum, cnt);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic result_t verdict_of(input logic [STATUS_W-1:0] st, input logic [31:0] c);
    result_t r;
    r = '0;
    r.result_kind    = KIND_VERDICT;
    r.status         = st;
    r.chosen_counter = c;
    r.active_bank    = c[0];
    return r;
  endfunction

  function automatic result_t sector_of(input logic v);
    result_t r;
    r = '0;
    r.result_kind  = KIND_SECTOR;
    r.sector_valid = v;
    return r;
  endfunction

  row_t dir_rows [$];

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int ph, target;
    logic [31:0] mg;
    logic [BIU_W-1:0] nb;
    row_t row;

    // after reset: magic 0, fourteen blocks
    dir_rows.push_back(item_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 1, verdict_of(ST_EMPTY, 0)));
    dir_rows.push_back(item_row(OP_SECTOR_END, 0, 0, 0, 0, 16'h0000, 5, 1, sector_of(1)));
    // one partial bank beside an empty one is destroyed
    dir_rows.push_back(item_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 1, verdict_of(ST_DESTROYED, 0)));
    // word sum wraps to zero
    dir_rows.push_back(item_row(OP_DATA, CNT_MAX, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(item_row(OP_DATA, 32'h0000_0001, 1, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(item_row(OP_SECTOR_END, 0, 1, 0, 31, 16'h0000, CNT_MAX, 1, sector_of(1)));
    // wrong id, then right id with a bad sum
    dir_rows.push_back(item_row(OP_SECTOR_END, 0, 0, CNT_MAX, 3, 16'h0000, 9, 1, sector_of(0)));
    dir_rows.push_back(item_row(OP_SECTOR_END, 0, 1, 0, 2, 16'hffff, 1, 1, sector_of(0)));
    // carry of the 16-bit fold
    dir_rows.push_back(item_row(OP_DATA, CNT_MAX, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(item_row(OP_DATA, CNT_MAX, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(item_row(OP_SECTOR_END, 0, 0, 0, 1, 16'hfffd, 2, 0, '0));
    dir_rows.push_back(item_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(item_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(item_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 1, verdict_of(ST_EMPTY, 0)));
    // one block per bank, all-ones magic
    dir_rows.push_back(cfg_row(CFG_BLOCKS_IN_USE, 1));
    dir_rows.push_back(cfg_row(CFG_SAVE_MAGIC, CNT_MAX));
    dir_rows.push_back(item_row(OP_SECTOR_END, 0, 0, CNT_MAX, 0, 0, CNT_ZERO, 1, sector_of(1)));
    dir_rows.push_back(item_row(OP_SECTOR_END, 0, 1, CNT_MAX, 0, 0, CNT_MAX, 0, '0));
    // counter wrap: zero wins over all ones
    dir_rows.push_back(item_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 1, verdict_of(ST_OK, CNT_ZERO)));
    dir_rows.push_back(item_row(OP_SECTOR_END, 0, 0, CNT_MAX, 0, 0, 7, 0, '0));
    dir_rows.push_back(item_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, '0));
    // extra block makes bank 1 damaged
    dir_rows.push_back(item_row(OP_SECTOR_END, 0, 1, CNT_MAX, 5, 0, 3, 0, '0));
    dir_rows.push_back(item_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, '0));
    // zero block count: present with an empty mask is complete
    dir_rows.push_back(cfg_row(CFG_BLOCKS_IN_USE, 0));
    dir_rows.push_back(item_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(item_row(OP_SECTOR_END, 0, 0, CNT_MAX, 4, 16'h1234, 8, 1, sector_of(0)));
    dir_rows.push_back(item_row(OP_FINISH, 0, 0, 0, 0, 0, 0, 0, '0));

    // reset held, then released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) write_reg(row.cfg_idx, row.cfg_val);
      else send_item(row.it, row.typed, row.want);
    end

    // random phases: register setting and idle pattern per phase
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      mg = $urandom;
      case (ph)
        0: nb = 1;
        1: begin mg = CNT_MAX; nb = 32; end
        2: begin mg = CNT_ZERO; nb = 3; end
        3: nb = 0;
        4: nb = 63;
        5: nb = $urandom_range(1, 6);
        6: nb = 2;
        default: nb = 14;
      endcase
      write_reg(CFG_SAVE_MAGIC, mg);
      write_reg(CFG_BLOCKS_IN_USE, {26'd0, nb});
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      // back-pressure: result side blocked while items keep coming
      if (ph == 4) hold_left = 400;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 4))
            send_item(mk_item($urandom_range(0, 3), $urandom, $urandom_range(0, 1), $urandom,
                              $urandom_range(0, 31), $urandom_range(0, 65535), $urandom),
                      1'b0, '0);
        end else begin
          play_save();
        end
      end
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("** dual_bank_save_validator: PASSED **");
    end else begin
      $display("** dual_bank_save_validator: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: dual_bank_save_validator.f
rtl/dbsv_pkg.sv
rtl/dbsv_bank_state.sv
rtl/dbsv_verdict.sv
rtl/dual_bank_save_validator.sv
tb/sv/tb_dual_bank_save_validator.sv
